FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CMTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Property that must hold in the cycle after a trigger.
`define CMTC_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

FILE: hdl/cmtc_pkg.sv
// Package with the types, constants and log table of the context model classifier.
package cmtc_pkg;

    localparam int SYM_BITS   = 4;
    localparam int MAX_ORDER  = 3;
    localparam int CTX_BITS   = SYM_BITS * MAX_ORDER;
    localparam int CTX_COUNT  = 1 << CTX_BITS;
    localparam int SLOTS      = 17;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int TOTAL_SLOT = 16;
    localparam int UNMAPPED   = 16;
    localparam int CODE_W     = 5;
    localparam int COUNT_BITS = 24;
    localparam int LOG_FRAC   = 16;
    localparam int ALPHA_W    = 9;
    localparam int N_W        = 5;
    localparam int K_W        = 2;
    localparam int LEN_W      = 3;
    localparam int AN_W       = ALPHA_W + N_W;
    localparam int LOG_IN_W   = COUNT_BITS + 9;
    localparam int EXP_W      = $clog2(LOG_IN_W);
    localparam int LOG_W      = EXP_W + LOG_FRAC;
    localparam int ACC_W      = 48;
    localparam int CNT_W      = 32;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PIPE_DEPTH = 7;

    typedef enum logic [1:0] {
        FUNC_TEXT  = 2'd0,
        FUNC_END   = 2'd1,
        FUNC_MAP   = 2'd2,
        FUNC_COUNT = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_ALPHABET = 2'd0,
        CFG_ALPHA    = 2'd1,
        CFG_ORDER    = 2'd2
    } t_cfg_reg;

    // Control word that travels down the cost pipeline beside the data.
    typedef struct packed {
        logic vld;
        logic eos;
        logic add;
        logic too_short;
    } t_ctl;

    typedef struct packed {
        logic [CNT_W-1:0] ai_total;
        logic [CNT_W-1:0] human_total;
        logic [ACC_W-1:0] ai_cost;
        logic [ACC_W-1:0] human_cost;
        logic             classified_ai;
        logic             too_short;
        logic [CNT_W-1:0] sample_number;
    } t_result;

    typedef logic [255:0][LOG_FRAC-1:0] t_log_tab;

    // log2(1 + m/256) by repeated squaring of a Q30 mantissa, truncated.
    function automatic t_log_tab build_log_tab();
        t_log_tab          tab;
        logic [63:0]       y;
        logic [LOG_FRAC-1:0] r;
        int                i;
        int                b;
        for (i = 0; i < 256; i++) begin
            y = 64'(256 + i) << 22;
            r = '0;
            for (b = 0; b < LOG_FRAC; b++) begin
                y = (y * y) >> 30;
                r = {r[LOG_FRAC-2:0], 1'b0};
                if (y >= (64'd2 << 30)) begin
                    r[0] = 1'b1;
                    y    = y >> 1;
                end
            end
            tab[i] = r;
        end
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();

endpackage

FILE: hdl/cmtc_log2.sv
// Three-stage fixed-point log2 unit: leading-one search, normalize, table add.
module cmtc_log2
    import cmtc_pkg::*;
(
    input  logic                i_clk,
    input  logic [LOG_IN_W-1:0] i_x,
    output logic [LOG_W-1:0]    o_log
);

    logic [EXP_W-1:0]    w_e;
    logic [LOG_IN_W-1:0] r_x1;
    logic [EXP_W-1:0]    r_e1;
    logic [LOG_IN_W-1:0] w_norm;
    logic [EXP_W-1:0]    r_e2;
    logic [7:0]          r_m2;
    logic [LOG_W-1:0]    r_log;

    // Index of the highest set bit; a zero input reads as one.
    always_comb begin
        w_e = '0;
        for (int j = 0; j < LOG_IN_W; j++) begin
            if (i_x[j]) begin
                w_e = EXP_W'(j);
            end
        end
    end

    assign w_norm = r_x1 << (EXP_W'(LOG_IN_W - 1) - r_e1);

    always_ff @(posedge i_clk) begin
        r_x1  <= i_x;
        r_e1  <= w_e;
        r_e2  <= r_e1;
        r_m2  <= w_norm[LOG_IN_W-2 -: 8];
        r_log <= {r_e2, LOG_TAB[r_m2]};
    end

    assign o_log = r_log;

endmodule

FILE: hdl/context_model_text_classifier.sv
// Top level of the order-k context model text classifier.
//
//  Channel   Ports          Payload (lowest bit up)
//  input     s_axis_*       tuser: func; tdata: byte_value, symbol_code, model_select,
//                           context_index, count_slot, count_value
//  result    m_axis_*       tdata: sample_number, too_short, classified_ai, human_cost,
//                           ai_cost, human_total, ai_total
//  config    i_cfg_*        write enable, register index, 9-bit data
//
// Every transaction enters an eight-stage pipeline: symbol map read, count memory read,
// ratio build, three stages of the log2 units, cost, and the accumulators. One input
// transaction is taken per cycle while s_axis_tready is high, and an end item passes
// stages A, B, C, the three log2 stages and F before its result enters the FIFO.
// The count memories are read whole rows at a time, one row per model, so a text byte
// needs a single row read per model. After reset a clearing pass over all 4096 contexts
// wipes the context present bits; no input transaction is accepted during it.
// Results queue in a 16-entry FIFO; input is held off when the FIFO could not take the
// end items that may still be in flight, so an output stall never stalls the pipeline.
`include "assert_macros.svh"

module context_model_text_classifier
    import cmtc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // byte_value, symbol_code, model_select, context_index, count_slot, count_value
    input  logic [55:0]  s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sample_number, too_short, classified_ai, human_cost, ai_cost, human_total, ai_total
    output logic [199:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [8:0]   i_cfg_data
);

    // Input field views.
    t_func                 w_func;
    logic [7:0]            w_byte;
    logic [CODE_W-1:0]     w_code;
    logic                  w_model;
    logic [CTX_BITS-1:0]   w_ctx_in;
    logic [SLOT_W-1:0]     w_slot;
    logic [COUNT_BITS-1:0] w_value;
    logic                  w_in_acc;

    assign w_func   = t_func'(s_axis_tuser);
    assign w_byte   = s_axis_tdata[7:0];
    assign w_code   = s_axis_tdata[12:8];
    assign w_model  = s_axis_tdata[13];
    assign w_ctx_in = s_axis_tdata[25:14];
    assign w_slot   = s_axis_tdata[30:26];
    assign w_value  = s_axis_tdata[54:31];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // Configuration registers and their clamped values.
    logic [N_W-1:0]     r_alphabet_size;
    logic [ALPHA_W-1:0] r_smoothing_alpha;
    logic [K_W-1:0]     r_context_length;
    logic [N_W-1:0]     w_n;
    logic [ALPHA_W-1:0] w_alpha;
    logic [K_W-1:0]     w_k;
    logic [AN_W-1:0]    w_alpha_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_size   <= N_W'(16);
            r_smoothing_alpha <= ALPHA_W'(256);
            r_context_length  <= K_W'(3);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALPHABET: r_alphabet_size   <= i_cfg_data[N_W-1:0];
                CFG_ALPHA:    r_smoothing_alpha <= i_cfg_data;
                CFG_ORDER:    r_context_length  <= i_cfg_data[K_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        if (r_alphabet_size < N_W'(2)) begin
            w_n = N_W'(2);
        end else if (r_alphabet_size > N_W'(16)) begin
            w_n = N_W'(16);
        end else begin
            w_n = r_alphabet_size;
        end
        if (r_smoothing_alpha == '0) begin
            w_alpha = ALPHA_W'(1);
        end else if (r_smoothing_alpha > ALPHA_W'(256)) begin
            w_alpha = ALPHA_W'(256);
        end else begin
            w_alpha = r_smoothing_alpha;
        end
        w_k = (r_context_length == '0) ? K_W'(1) : r_context_length;
    end

    assign w_alpha_n = AN_W'(w_alpha) * AN_W'(w_n);

    // Clearing pass over the present bits after reset.
    logic                r_clr_busy;
    logic [CTX_BITS-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Result FIFO bookkeeping; the space check covers every stage that can hold an end item.
    logic [FIFO_AW:0] r_fifo_cnt;
    assign s_axis_tready = !r_clr_busy && (r_fifo_cnt <= (FIFO_AW+1)'(FIFO_DEPTH - PIPE_DEPTH - 1));

    // Symbol map: 256 entries, each unmapped until its valid bit is set.
    logic [CODE_W-1:0] r_map_mem [256];
    logic [255:0]      r_map_vld;
    logic [CODE_W-1:0] r_map_q;
    logic              r_map_hit;

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_func == FUNC_MAP) begin
            r_map_mem[w_byte] <= (w_code > CODE_W'(UNMAPPED)) ? CODE_W'(UNMAPPED) : w_code;
        end
        r_map_q   <= r_map_mem[w_byte];
        r_map_hit <= r_map_vld[w_byte];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
        end else if (w_in_acc && w_func == FUNC_MAP) begin
            r_map_vld[w_byte] <= 1'b1;
        end
    end

    // Stage A: the accepted transaction with its symbol map read.
    logic                  r_a_vld;
    t_func                 r_a_func;
    logic                  r_a_model;
    logic [CTX_BITS-1:0]   r_a_ctx;
    logic [SLOT_W-1:0]     r_a_slot;
    logic [COUNT_BITS-1:0] r_a_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_in_acc;
        end
        r_a_func  <= w_func;
        r_a_model <= w_model;
        r_a_ctx   <= w_ctx_in;
        r_a_slot  <= w_slot;
        r_a_value <= w_value;
    end

    // Per-sample context state, updated in stage A.
    logic [CTX_BITS-1:0] r_hist;
    logic [LEN_W-1:0]    r_raw;
    logic [LEN_W-1:0]    r_clean;
    logic [CTX_BITS-1:0] n_hist;
    logic [LEN_W-1:0]    n_raw;
    logic [LEN_W-1:0]    n_clean;
    logic [CODE_W-1:0]   w_sym;
    logic [CTX_BITS-1:0] w_mask;
    logic [CTX_BITS-1:0] w_ctx;
    logic                w_a_text;
    logic                w_a_end;
    logic                w_a_sym_ok;
    logic                w_a_add;
    t_ctl                n_b_ctl;

    assign w_sym      = r_map_hit ? r_map_q : CODE_W'(UNMAPPED);
    assign w_a_text   = r_a_vld && r_a_func == FUNC_TEXT;
    assign w_a_end    = r_a_vld && r_a_func == FUNC_END;
    assign w_a_sym_ok = w_a_text && (w_sym < w_n);
    assign w_a_add    = w_a_sym_ok && (r_clean >= LEN_W'(w_k));
    assign w_ctx      = r_hist & w_mask;

    always_comb begin
        unique case (w_k)
            K_W'(1):  w_mask = CTX_BITS'(12'h00f);
            K_W'(2):  w_mask = CTX_BITS'(12'h0ff);
            default:  w_mask = CTX_BITS'(12'hfff);
        endcase
    end

    always_comb begin
        n_hist  = r_hist;
        n_raw   = r_raw;
        n_clean = r_clean;
        if (w_a_end) begin
            n_hist  = '0;
            n_raw   = '0;
            n_clean = '0;
        end else if (w_a_text) begin
            if (r_raw != '1) begin
                n_raw = r_raw + 1'b1;
            end
            if (w_a_sym_ok) begin
                n_hist = ((w_ctx << SYM_BITS) | CTX_BITS'(w_sym[SYM_BITS-1:0])) & w_mask;
                if (r_clean != '1) begin
                    n_clean = r_clean + 1'b1;
                end
            end
        end
        n_b_ctl.vld       = w_a_add || w_a_end;
        n_b_ctl.eos       = w_a_end;
        n_b_ctl.add       = w_a_add;
        n_b_ctl.too_short = r_raw <= LEN_W'(w_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_raw   <= '0;
            r_clean <= '0;
        end else begin
            r_hist  <= n_hist;
            r_raw   <= n_raw;
            r_clean <= n_clean;
        end
    end

    // Count memories, one per model, a row per context holding all slots and the total.
    logic [SLOTS-1:0][COUNT_BITS-1:0] r_cnt_h [CTX_COUNT];
    logic [SLOTS-1:0][COUNT_BITS-1:0] r_cnt_a [CTX_COUNT];
    logic                             r_pres_h [CTX_COUNT];
    logic                             r_pres_a [CTX_COUNT];
    logic [SLOTS-1:0][COUNT_BITS-1:0] r_b_row_h;
    logic [SLOTS-1:0][COUNT_BITS-1:0] r_b_row_a;
    logic                             r_b_pres_h;
    logic                             r_b_pres_a;
    logic                             w_cnt_we;

    assign w_cnt_we = r_a_vld && r_a_func == FUNC_COUNT && r_a_slot <= SLOT_W'(TOTAL_SLOT);

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_pres_h[r_clr_addr] <= 1'b0;
            r_pres_a[r_clr_addr] <= 1'b0;
        end else if (w_cnt_we) begin
            if (r_a_model) begin
                r_pres_a[r_a_ctx]           <= 1'b1;
                r_cnt_a[r_a_ctx][r_a_slot] <= r_a_value;
            end else begin
                r_pres_h[r_a_ctx]           <= 1'b1;
                r_cnt_h[r_a_ctx][r_a_slot] <= r_a_value;
            end
        end
        r_b_row_h  <= r_cnt_h[w_ctx];
        r_b_row_a  <= r_cnt_a[w_ctx];
        r_b_pres_h <= r_pres_h[w_ctx];
        r_b_pres_a <= r_pres_a[w_ctx];
    end

    // Stage B: select the symbol count and total, build numerator and denominator.
    t_ctl                r_b_ctl;
    logic [SYM_BITS-1:0] r_b_sym;
    logic [LOG_IN_W-1:0] w_num_h;
    logic [LOG_IN_W-1:0] w_den_h;
    logic [LOG_IN_W-1:0] w_num_a;
    logic [LOG_IN_W-1:0] w_den_a;
    logic [SLOT_W-1:0]   w_sym_slot;

    assign w_sym_slot = {1'b0, r_b_sym};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else begin
            r_b_ctl <= n_b_ctl;
        end
        r_b_sym <= w_sym[SYM_BITS-1:0];
    end

    // An absent context costs log2(n): log2(n) - log2(1).
    always_comb begin
        if (r_b_pres_h) begin
            w_num_h = {1'b0, r_b_row_h[w_sym_slot], 8'b0} + LOG_IN_W'(w_alpha);
            w_den_h = {1'b0, r_b_row_h[SLOT_W'(TOTAL_SLOT)], 8'b0} + LOG_IN_W'(w_alpha_n);
        end else begin
            w_num_h = LOG_IN_W'(1);
            w_den_h = LOG_IN_W'(w_n);
        end
        if (r_b_pres_a) begin
            w_num_a = {1'b0, r_b_row_a[w_sym_slot], 8'b0} + LOG_IN_W'(w_alpha);
            w_den_a = {1'b0, r_b_row_a[SLOT_W'(TOTAL_SLOT)], 8'b0} + LOG_IN_W'(w_alpha_n);
        end else begin
            w_num_a = LOG_IN_W'(1);
            w_den_a = LOG_IN_W'(w_n);
        end
    end

    // Stage C and the three log2 stages.
    t_ctl                r_c_ctl;
    t_ctl                r_d1_ctl;
    t_ctl                r_d2_ctl;
    t_ctl                r_d3_ctl;
    logic [LOG_IN_W-1:0] r_c_num_h;
    logic [LOG_IN_W-1:0] r_c_den_h;
    logic [LOG_IN_W-1:0] r_c_num_a;
    logic [LOG_IN_W-1:0] r_c_den_a;
    logic [LOG_W-1:0]    w_ln_h;
    logic [LOG_W-1:0]    w_ld_h;
    logic [LOG_W-1:0]    w_ln_a;
    logic [LOG_W-1:0]    w_ld_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl  <= '0;
            r_d1_ctl <= '0;
            r_d2_ctl <= '0;
            r_d3_ctl <= '0;
        end else begin
            r_c_ctl  <= r_b_ctl;
            r_d1_ctl <= r_c_ctl;
            r_d2_ctl <= r_d1_ctl;
            r_d3_ctl <= r_d2_ctl;
        end
        r_c_num_h <= w_num_h;
        r_c_den_h <= w_den_h;
        r_c_num_a <= w_num_a;
        r_c_den_a <= w_den_a;
    end

    cmtc_log2 u_log_num_h (.i_clk(i_clk), .i_x(r_c_num_h), .o_log(w_ln_h));
    cmtc_log2 u_log_den_h (.i_clk(i_clk), .i_x(r_c_den_h), .o_log(w_ld_h));
    cmtc_log2 u_log_num_a (.i_clk(i_clk), .i_x(r_c_num_a), .o_log(w_ln_a));
    cmtc_log2 u_log_den_a (.i_clk(i_clk), .i_x(r_c_den_a), .o_log(w_ld_a));

    // Stage F: per-symbol cost, clipped at zero when log2 of the numerator reaches that of the denominator.
    t_ctl             r_f_ctl;
    logic [LOG_W-1:0] r_f_cost_h;
    logic [LOG_W-1:0] r_f_cost_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_ctl <= '0;
        end else begin
            r_f_ctl <= r_d3_ctl;
        end
        r_f_cost_h <= (w_ld_h > w_ln_h) ? (w_ld_h - w_ln_h) : '0;
        r_f_cost_a <= (w_ld_a > w_ln_a) ? (w_ld_a - w_ln_a) : '0;
    end

    // Accumulators, verdict and counters.
    logic [ACC_W-1:0] r_acc_h;
    logic [ACC_W-1:0] r_acc_a;
    logic [CNT_W-1:0] r_samples;
    logic [CNT_W-1:0] r_human_cnt;
    logic [CNT_W-1:0] r_ai_cnt;
    logic [ACC_W:0]   w_sum_h;
    logic [ACC_W:0]   w_sum_a;
    logic             w_push;
    logic             w_verdict;
    t_result          w_result;

    assign w_sum_h   = {1'b0, r_acc_h} + (ACC_W+1)'(r_f_cost_h);
    assign w_sum_a   = {1'b0, r_acc_a} + (ACC_W+1)'(r_f_cost_a);
    assign w_push    = r_f_ctl.vld && r_f_ctl.eos;
    assign w_verdict = !r_f_ctl.too_short && (r_acc_h > r_acc_a);

    always_comb begin
        w_result.sample_number = (&r_samples) ? r_samples : r_samples + 1'b1;
        w_result.too_short     = r_f_ctl.too_short;
        w_result.classified_ai = w_verdict;
        w_result.human_cost    = r_acc_h;
        w_result.ai_cost       = r_acc_a;
        w_result.human_total   = r_human_cnt;
        w_result.ai_total      = r_ai_cnt;
        if (!r_f_ctl.too_short) begin
            if (w_verdict) begin
                if (!(&r_ai_cnt)) begin
                    w_result.ai_total = r_ai_cnt + 1'b1;
                end
            end else if (!(&r_human_cnt)) begin
                w_result.human_total = r_human_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_h     <= '0;
            r_acc_a     <= '0;
            r_samples   <= '0;
            r_human_cnt <= '0;
            r_ai_cnt    <= '0;
        end else if (w_push) begin
            r_acc_h     <= '0;
            r_acc_a     <= '0;
            r_samples   <= w_result.sample_number;
            r_human_cnt <= w_result.human_total;
            r_ai_cnt    <= w_result.ai_total;
        end else if (r_f_ctl.vld && r_f_ctl.add) begin
            r_acc_h <= w_sum_h[ACC_W] ? '1 : w_sum_h[ACC_W-1:0];
            r_acc_a <= w_sum_a[ACC_W] ? '1 : w_sum_a[ACC_W-1:0];
        end
    end

    // Result FIFO.
    t_result            r_fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic               w_pop;

    assign m_axis_tvalid = r_fifo_cnt != '0;
    assign w_pop         = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {6'b0, r_fifo_mem[r_rd_ptr]};

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo_mem[r_wr_ptr] <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fifo_cnt <= r_fifo_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fifo_cnt <= r_fifo_cnt - 1'b1;
            end
        end
    end

    // Checks on the pipeline and the result queue.
    `CMTC_ASSERT(a_fifo_bound, r_fifo_cnt <= (FIFO_AW+1)'(FIFO_DEPTH), "result FIFO overflow")
    `CMTC_ASSERT(a_clear_blocks, r_clr_busy |-> !s_axis_tready, "input taken during clearing")
    `CMTC_ASSERT(a_one_kind, !(r_f_ctl.vld && r_f_ctl.eos && r_f_ctl.add), "end item marked as cost")
    `CMTC_ASSERT_NEXT(a_push_shows, w_push, m_axis_tvalid, "pushed result not presented")

endmodule

FILE: tb/context_model_text_classifier_tb.sv
// Testbench for the context model text classifier: directed and random samples checked against a predictor.
module context_model_text_classifier_tb;
    import cmtc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 30;
    localparam longint unsigned COST_MAX = (64'd1 << 48) - 1;

    // The verdict predictor keeps its own copy of the map, the count tables and the
    // per-sample accumulators, and queues one expected verdict per end-of-sample item.
    class verdict_scoreboard;
        bit [LOG_FRAC-1:0] frac_tab[256];
        bit [4:0]          sym_of_byte[256];
        bit                ctx_loaded[2*CTX_COUNT];
        bit [23:0]         counts[2*CTX_COUNT*SLOTS];
        bit [11:0]         history;
        int unsigned       raw_len;
        int unsigned       clean_len;
        longint unsigned   human_acc;
        longint unsigned   ai_acc;
        bit [31:0]         samples_seen;
        bit [31:0]         human_verdicts;
        bit [31:0]         ai_verdicts;
        bit [4:0]          reg_alphabet;
        bit [8:0]          reg_alpha;
        bit [1:0]          reg_order;
        t_result           verdicts_due[$];
        int                errors;

        function new();
            longint unsigned y;
            bit [LOG_FRAC-1:0] r;
            for (int m = 0; m < 256; m++) begin
                y = longint'(256 + m) << 22;
                r = '0;
                for (int b = 0; b < LOG_FRAC; b++) begin
                    y = (y * y) >> 30;
                    r = r << 1;
                    if (y >= (64'd1 << 31)) begin
                        r[0] = 1'b1;
                        y = y >> 1;
                    end
                end
                frac_tab[m] = r;
            end
            foreach (sym_of_byte[i]) sym_of_byte[i] = UNMAPPED;
            foreach (ctx_loaded[i]) ctx_loaded[i] = 1'b0;
            history = '0;
            raw_len = 0;
            clean_len = 0;
            human_acc = 0;
            ai_acc = 0;
            samples_seen = '0;
            human_verdicts = '0;
            ai_verdicts = '0;
            reg_alphabet = 5'd16;
            reg_alpha = 9'd256;
            reg_order = 2'd3;
            errors = 0;
        endfunction

        function int unsigned eff_symbols();
            return reg_alphabet < 2 ? 2 : (reg_alphabet > 16 ? 16 : reg_alphabet);
        endfunction

        function int unsigned eff_alpha();
            return reg_alpha < 1 ? 1 : (reg_alpha > 256 ? 256 : reg_alpha);
        endfunction

        function int unsigned eff_order();
            return reg_order < 1 ? 1 : reg_order;
        endfunction

        // Q16 log2: exponent of the top set bit plus the table entry for the next 8 bits.
        function longint unsigned log2_q16(longint unsigned x);
            int unsigned e;
            int unsigned m;
            e = 0;
            if (x == 0) x = 1;
            while (e < 63 && (x >> (e + 1)) != 0) e++;
            m = (e >= 8) ? ((x >> (e - 8)) & 255) : ((x << (8 - e)) & 255);
            return (longint'(e) << LOG_FRAC) + frac_tab[m];
        endfunction

        function longint unsigned symbol_cost(int unsigned model, int unsigned ctx,
                                              int unsigned sym);
            int unsigned base;
            longint unsigned num;
            longint unsigned den;
            longint unsigned ld;
            longint unsigned ln;
            if (!ctx_loaded[model*CTX_COUNT + ctx])
                return log2_q16(eff_symbols());
            base = (model*CTX_COUNT + ctx) * SLOTS;
            num = (longint'(counts[base + sym]) << 8) + eff_alpha();
            den = (longint'(counts[base + TOTAL_SLOT]) << 8)
                  + longint'(eff_alpha()) * eff_symbols();
            ld = log2_q16(den);
            ln = log2_q16(num);
            return ld > ln ? ld - ln : 0;
        endfunction

        function longint unsigned add_capped(longint unsigned acc, longint unsigned v);
            return (acc + v > COST_MAX) ? COST_MAX : acc + v;
        endfunction

        function void configure(t_cfg_reg idx, bit [8:0] data);
            case (idx)
                CFG_ALPHABET: reg_alphabet = data[4:0];
                CFG_ALPHA:    reg_alpha = data;
                CFG_ORDER:    reg_order = data[1:0];
                default: ;
            endcase
        endfunction

        function void note_input(t_func func, bit [7:0] byte_value, bit [4:0] code,
                                 bit model, bit [11:0] ctx, bit [4:0] slot,
                                 bit [23:0] value);
            int unsigned k;
            int unsigned sym;
            bit [11:0] mask;
            t_result res;
            k = eff_order();
            case (func)
                FUNC_MAP: sym_of_byte[byte_value] = (code > UNMAPPED) ? UNMAPPED : code;
                FUNC_COUNT: begin
                    if (slot <= TOTAL_SLOT) begin
                        counts[(model*CTX_COUNT + ctx)*SLOTS + slot] = value;
                        ctx_loaded[model*CTX_COUNT + ctx] = 1'b1;
                    end
                end
                FUNC_TEXT: begin
                    sym = sym_of_byte[byte_value];
                    mask = (12'd1 << (4*k)) - 1;
                    if (raw_len < 7) raw_len++;
                    if (sym < eff_symbols()) begin
                        history &= mask;
                        if (clean_len >= k) begin
                            human_acc = add_capped(human_acc, symbol_cost(0, history, sym));
                            ai_acc = add_capped(ai_acc, symbol_cost(1, history, sym));
                        end
                        history = ((history << 4) | sym) & mask;
                        if (clean_len < 7) clean_len++;
                    end
                end
                default: begin
                    res = '0;
                    if (samples_seen != 32'hFFFF_FFFF) samples_seen++;
                    res.too_short = (raw_len <= k);
                    if (!res.too_short) begin
                        if (human_acc > ai_acc) begin
                            res.classified_ai = 1'b1;
                            if (ai_verdicts != 32'hFFFF_FFFF) ai_verdicts++;
                        end else if (human_verdicts != 32'hFFFF_FFFF) begin
                            human_verdicts++;
                        end
                    end
                    res.sample_number = samples_seen;
                    res.human_cost = human_acc[47:0];
                    res.ai_cost = ai_acc[47:0];
                    res.human_total = human_verdicts;
                    res.ai_total = ai_verdicts;
                    verdicts_due.push_back(res);
                    history = '0;
                    raw_len = 0;
                    clean_len = 0;
                    human_acc = 0;
                    ai_acc = 0;
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.sample_number !== want.sample_number) begin
                $display("%0t: sample_number expected %0d actual %0d", $time,
                         want.sample_number, got.sample_number);
                errors++;
            end
            if (got.too_short !== want.too_short) begin
                $display("%0t: too_short expected %0d actual %0d", $time,
                         want.too_short, got.too_short);
                errors++;
            end
            if (got.classified_ai !== want.classified_ai) begin
                $display("%0t: classified_ai expected %0d actual %0d", $time,
                         want.classified_ai, got.classified_ai);
                errors++;
            end
            if (got.human_cost !== want.human_cost) begin
                $display("%0t: human_cost expected %h actual %h", $time,
                         want.human_cost, got.human_cost);
                errors++;
            end
            if (got.ai_cost !== want.ai_cost) begin
                $display("%0t: ai_cost expected %h actual %h", $time,
                         want.ai_cost, got.ai_cost);
                errors++;
            end
            if (got.human_total !== want.human_total) begin
                $display("%0t: human_total expected %0d actual %0d", $time,
                         want.human_total, got.human_total);
                errors++;
            end
            if (got.ai_total !== want.ai_total) begin
                $display("%0t: ai_total expected %0d actual %0d", $time,
                         want.ai_total, got.ai_total);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // byte_value, symbol_code, model_select, context_index, count_slot, count_value
    logic [55:0]  s_axis_tdata;
    // func
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // sample_number, too_short, classified_ai, human_cost, ai_cost, human_total, ai_total
    logic [199:0] m_axis_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [8:0]   i_cfg_data;

    verdict_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count;
    // Bytes currently mapped for the text generator.
    bit [7:0]    text_bytes[8];

    context_model_text_classifier uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The watchdog covers the clearing pass after reset as well.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: check each accepted transaction, then pick the next tready at random.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(t_result'(m_axis_tdata[$bits(t_result)-1:0]));
        m_axis_tready <= ($urandom_range(1, 100) > recv_stall_pct);
    end

    // Presents one input transaction, possibly after an idle gap, and waits until it is
    // taken. The predictor sees the item only once the handshake has completed.
    task automatic send_item(t_func func, bit [7:0] byte_value, bit [4:0] code,
                             bit model, bit [11:0] ctx, bit [4:0] slot, bit [23:0] value);
        if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {1'b0, value, slot, ctx, model, code, byte_value};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(func, byte_value, code, model, ctx, slot, value);
    endtask

    // Register writes happen only with the pipeline empty and no verdict outstanding.
    task automatic write_reg(t_cfg_reg idx, bit [8:0] data);
        s_axis_tvalid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.configure(idx, data);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic bit [23:0] random_count();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return 24'($urandom_range(0, 60));
        if (pick < 8) return 24'($urandom);
        return (pick == 8) ? 24'hFF_FFFF : 24'h0;
    endfunction

    // Loads every slot of one context so a later lookup never lands on an unwritten
    // count. An out-of-range slot write is slipped in now and then; it must be ignored.
    task automatic load_context(bit model, bit [11:0] ctx);
        bit [23:0] total;
        bit [23:0] cnt;
        total = random_count();
        for (int s = 0; s <= TOTAL_SLOT; s++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(FUNC_COUNT, 8'($urandom), 5'($urandom), model, ctx,
                          5'($urandom_range(17, 31)), 24'($urandom));
            if (s == TOTAL_SLOT)
                cnt = total;
            else if ($urandom_range(0, 9) < 8)
                cnt = (total == 0) ? 24'h0 : 24'($urandom_range(0, total));
            else
                cnt = random_count();
            send_item(FUNC_COUNT, 8'($urandom), 5'($urandom), model, ctx, 5'(s), cnt);
        end
    endtask

    // One phase: new settings, a fresh text alphabet, a few loaded contexts, then samples.
    task automatic run_phase(int phase, bit [4:0] n_raw, bit [8:0] alpha_raw,
                             bit [1:0] k_raw, int budget);
        int unsigned n;
        int unsigned used;
        int unsigned len;
        int sent;
        bit [11:0] ctx;
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
        write_reg(CFG_ALPHABET, {4'($urandom), n_raw});
        write_reg(CFG_ALPHA, alpha_raw);
        write_reg(CFG_ORDER, {7'($urandom), k_raw});
        n = sb.eff_symbols();
        used = (n < 4) ? n : 4;
        // Most text bytes carry a few low symbols so that loaded contexts recur; the
        // last one points past the alphabet and must be skipped.
        for (int i = 0; i < 8; i++) begin
            text_bytes[i] = 8'($urandom);
            send_item(FUNC_MAP, text_bytes[i],
                      (i == 7) ? 5'($urandom_range(n, 16)) : 5'($urandom_range(0, used - 1)),
                      1'b0, '0, '0, '0);
        end
        for (int g = 0; g < 4; g++) begin
            if (g == 3)
                ctx = 12'($urandom);
            else
                ctx = {4'($urandom_range(0, used - 1)), 4'($urandom_range(0, used - 1)),
                       4'($urandom_range(0, used - 1))};
            load_context(1'($urandom), ctx);
        end
        sent = 0;
        while (sent < budget) begin
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) < 8)
                    send_item(FUNC_TEXT, text_bytes[$urandom_range(0, 7)], 5'($urandom),
                              1'($urandom), 12'($urandom), 5'($urandom), 24'($urandom));
                else
                    send_item(FUNC_TEXT, 8'($urandom), 5'($urandom), 1'($urandom),
                              12'($urandom), 5'($urandom), 24'($urandom));
            end
            // Noise: now and then a stray map write of an unmapped code, just before the end item.
            if ($urandom_range(0, 19) == 0)
                send_item(FUNC_MAP, 8'($urandom), 5'($urandom_range(16, 31)), 1'b0, '0, '0,
                          '0);
            send_item(FUNC_END, 8'($urandom), 5'($urandom), 1'($urandom), 12'($urandom),
                      5'($urandom), 24'($urandom));
            sent += len + 1;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = FUNC_TEXT;
        m_axis_tready  = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_ALPHABET;
        i_cfg_data     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening under reset settings: an empty sample, an unmapped byte,
        // map extremes, an ignored slot write, a too-short sample, and a sample whose
        // contexts are all absent so every symbol costs log2 of the alphabet size.
        send_item(FUNC_END, '0, '0, 1'b0, '0, '0, '0);
        send_item(FUNC_TEXT, 8'hFF, '0, 1'b0, '0, '0, '0);
        send_item(FUNC_END, '0, '0, 1'b0, '0, '0, '0);
        send_item(FUNC_MAP, 8'h00, 5'd0, 1'b0, '0, '0, '0);
        send_item(FUNC_MAP, 8'hFF, 5'd15, 1'b0, '0, '0, '0);
        send_item(FUNC_MAP, 8'h80, 5'd31, 1'b0, '0, '0, '0);
        send_item(FUNC_COUNT, '0, '0, 1'b1, 12'hFFF, 5'd31, 24'hFF_FFFF);
        send_item(FUNC_TEXT, 8'h00, '0, 1'b0, '0, '0, '0);
        send_item(FUNC_TEXT, 8'hFF, '0, 1'b0, '0, '0, '0);
        send_item(FUNC_TEXT, 8'h80, '0, 1'b0, '0, '0, '0);
        send_item(FUNC_END, '0, '0, 1'b0, '0, '0, '0);
        for (int i = 0; i < 6; i++)
            send_item(FUNC_TEXT, (i % 2) ? 8'hFF : 8'h00, '0, 1'b0, '0, '0, '0);
        send_item(FUNC_END, '0, '0, 1'b0, '0, '0, '0);

        // Settings sweep, out-of-range values included to exercise the clamping.
        run_phase(0, 5'd16, 9'd256, 2'd3, 120);
        run_phase(1, 5'd2,  9'd1,   2'd1, 120);
        run_phase(2, 5'd0,  9'd0,   2'd0, 120);
        run_phase(3, 5'd31, 9'd511, 2'd3, 120);
        run_phase(4, 5'd4,  9'd128, 2'd2, 120);
        run_phase(5, 5'd17, 9'd300, 2'd1, 120);
        run_phase(6, 5'd8,  9'd1,   2'd3, 120);
        run_phase(7, 5'd3,  9'd256, 2'd2, 120);

        while (sb.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/cmtc_pkg.sv
hdl/cmtc_log2.sv
hdl/context_model_text_classifier.sv
tb/context_model_text_classifier_tb.sv
